### rtl/core/hgom_pkg.sv
// Shared constants and types of the height grid obstacle mapper.
// Grid geometry, field widths and the stored cell layout; no dependencies.
package hgom_pkg;

   localparam int GRID_CELLS = 400;
   localparam int HALF_CELLS = GRID_CELLS / 2;
   localparam int NUM_CELLS  = GRID_CELLS * GRID_CELLS;
   localparam int ADDR_W     = $clog2(NUM_CELLS);
   localparam int BIN_W      = $clog2(GRID_CELLS);

   localparam int COORD_W    = 16;
   localparam int IDX_W      = 9;
   localparam int CS_W       = 10;
   localparam int THR_W      = 16;
   localparam int CSR_W      = 16;
   localparam int CS_MAX     = (1 << CS_W) - 1;
   localparam int EXT_W      = $clog2(GRID_CELLS * CS_MAX + 1);
   localparam int BDIV_W     = (EXT_W > CS_W + BIN_W) ? EXT_W : CS_W + BIN_W;

   localparam int SUM_W      = 32;
   localparam int CNT_W      = 16;
   localparam int MEAN_W     = CNT_W + 1;

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [CNT_W-1:0]        count;
   } cell_type;

endpackage

### rtl/core/height_grid_obstacle_mapper.sv
// Height grid obstacle mapper top level: request decode, control sequencer, result register.
// An in-range point runs the index divider, a cell read and a write back;
// a read request reads the cell and, if the cell is filled, then runs the mean divider.
// Throughput: one request at a time; a new request is taken while a result waits.
// Reset and each new frame run a clearing pass over all NUM_CELLS (160000) cells.
module height_grid_obstacle_mapper
   import hgom_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // x_mm[15:0], y_mm[31:16], z_mm[47:32], row[56:48], col[65:57]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // in_range[0], mean_height_mm[16:1], point_count[32:17],
                                   // obstacle[33]
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam logic CSR_CELL_SIZE = 1'b0;
   localparam logic CSR_THRESHOLD = 1'b1;

   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_READ  = 2'd1,
      FUNC_FRAME = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_BIN, S_LOOKUP, S_RMW, S_CHECK, S_DIV, S_DONE
   } state_type;

   typedef struct packed {
      logic                    obstacle;
      logic [CNT_W-1:0]        point_count;
      logic signed [15:0]      mean_height_mm;
      logic                    in_range;
   } rsp_type;

   state_type              state_ff;
   func_type               func_ff;
   logic                   clr_pend_ff;
   logic [ADDR_W-1:0]      clr_addr_ff;
   logic [ADDR_W-1:0]      idx_ff;
   logic signed [COORD_W-1:0] y_ff;
   rsp_type                work_ff;
   rsp_type                rsp_data_ff;
   logic                   rsp_valid_ff;
   logic [CS_W-1:0]        cs_ff;
   logic [EXT_W-1:0]       half_ff;
   logic [EXT_W-1:0]       extent_ff;
   logic signed [THR_W-1:0] thr_ff;

   logic [CS_W-1:0]        cs_in;
   logic [EXT_W-1:0]       half_in;
   logic [EXT_W-1:0]       extent_in;
   rsp_type                work_in;

   func_type               req_func;
   logic signed [COORD_W-1:0] req_x;
   logic signed [COORD_W-1:0] req_y;
   logic signed [COORD_W-1:0] req_z;
   logic [IDX_W-1:0]       req_row;
   logic [IDX_W-1:0]       req_col;
   logic                   accept;
   logic signed [EXT_W:0]  x_off;
   logic signed [EXT_W:0]  z_ext;
   logic signed [EXT_W:0]  ext_s;
   logic                   in_grid;
   logic                   rd_ok;
   logic [ADDR_W-1:0]      rd_idx;

   logic                   bin_start;
   logic                   bin_done;
   logic [BIN_W-1:0]       bin_col_q;
   logic [BIN_W-1:0]       bin_row_q;
   logic [BIN_W-1:0]       bin_col;
   logic [BIN_W-1:0]       bin_row;
   logic [ADDR_W-1:0]      add_idx;

   logic                   mean_start;
   logic                   mean_done;
   logic signed [MEAN_W-1:0] mean_val;

   logic                   ram_wen;
   logic [ADDR_W-1:0]      ram_waddr;
   cell_type               ram_wdata;
   logic                   ram_ren;
   cell_type               ram_rdata;
   logic                   cell_full;

   assign req_func = func_type'(req_tuser);
   assign req_x    = req_tdata[15:0];
   assign req_y    = req_tdata[31:16];
   assign req_z    = req_tdata[47:32];
   assign req_row  = req_tdata[56:48];
   assign req_col  = req_tdata[65:57];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign cs_in     = (csr_wdata[CS_W-1:0] == '0) ? CS_W'(1) : csr_wdata[CS_W-1:0];
   assign half_in   = EXT_W'(cs_in) * EXT_W'(HALF_CELLS);
   assign extent_in = EXT_W'(cs_in) * EXT_W'(GRID_CELLS);

   assign x_off   = (EXT_W+1)'(req_x) + $signed({1'b0, half_ff});
   assign z_ext   = (EXT_W+1)'(req_z);
   assign ext_s   = $signed({1'b0, extent_ff});
   assign in_grid = (x_off > 0) && (x_off < ext_s) && (z_ext > 0) && (z_ext < ext_s);

   assign rd_ok  = (32'(req_row) < 32'(GRID_CELLS)) && (32'(req_col) < 32'(GRID_CELLS));
   assign rd_idx = ADDR_W'(req_row) * ADDR_W'(GRID_CELLS) + ADDR_W'(req_col);

   always_comb begin
      work_in = '0;
      case (req_func)
         FUNC_ADD: begin
            work_in.in_range = in_grid;
         end
         FUNC_READ: begin
            work_in.in_range = rd_ok;
         end
         default: begin
         end
      endcase
   end

   assign bin_start = accept && (req_func == FUNC_ADD) && in_grid;
   assign bin_col = (32'(bin_col_q) >= 32'(GRID_CELLS)) ? BIN_W'(GRID_CELLS - 1) : bin_col_q;
   assign bin_row = (32'(bin_row_q) >= 32'(GRID_CELLS)) ? BIN_W'(GRID_CELLS - 1) : bin_row_q;
   assign add_idx = ADDR_W'(bin_row) * ADDR_W'(GRID_CELLS) + ADDR_W'(bin_col);

   hgom_bin_div u_bin_div (
      .clock   (clock),
      .reset   (reset),
      .start   (bin_start),
      .divisor (cs_ff),
      .dvd_a   (x_off[EXT_W-1:0]),
      .dvd_b   (z_ext[EXT_W-1:0]),
      .done    (bin_done),
      .quot_a  (bin_col_q),
      .quot_b  (bin_row_q)
   );

   assign mean_start = (state_ff == S_CHECK) && (ram_rdata.count != '0);

   hgom_mean_div u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .start    (mean_start),
      .dividend (ram_rdata.sum),
      .divisor  (ram_rdata.count),
      .done     (mean_done),
      .mean     (mean_val)
   );

   assign cell_full = (ram_rdata.count == {CNT_W{1'b1}});
   assign ram_ren   = (state_ff == S_LOOKUP);
   assign ram_wen   = (state_ff == S_CLEAR) || ((state_ff == S_RMW) && !cell_full);
   assign ram_waddr = (state_ff == S_CLEAR) ? clr_addr_ff : idx_ff;

   always_comb begin
      ram_wdata = '0;
      if (state_ff == S_RMW) begin
         ram_wdata.sum   = ram_rdata.sum + SUM_W'(y_ff);
         ram_wdata.count = ram_rdata.count + 1'b1;
      end
   end

   hgom_cell_ram u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wen),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_ren),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         func_ff      <= FUNC_ADD;
         clr_pend_ff  <= 1'b0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         cs_ff        <= CS_W'(10);
         half_ff      <= EXT_W'(HALF_CELLS * 10);
         extent_ff    <= EXT_W'(GRID_CELLS * 10);
         thr_ff       <= THR_W'(100);
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_CELL_SIZE: begin
                  cs_ff     <= cs_in;
                  half_ff   <= half_in;
                  extent_ff <= extent_in;
               end
               CSR_THRESHOLD: begin
                  thr_ff <= csr_wdata[THR_W-1:0];
               end
               default: begin
               end
            endcase
         end

         if (rsp_valid_ff && rsp_tready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == ADDR_W'(NUM_CELLS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  work_ff <= work_in;
                  func_ff <= req_func;
                  y_ff    <= req_y;
                  idx_ff  <= rd_idx;
                  case (req_func)
                     FUNC_ADD: begin
                        state_ff <= in_grid ? S_BIN : S_DONE;
                     end
                     FUNC_READ: begin
                        state_ff <= rd_ok ? S_LOOKUP : S_DONE;
                     end
                     FUNC_FRAME: begin
                        clr_pend_ff <= 1'b1;
                        clr_addr_ff <= '0;
                        state_ff    <= S_DONE;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_BIN: begin
               if (bin_done) begin
                  idx_ff   <= add_idx;
                  state_ff <= S_LOOKUP;
               end
            end
            S_LOOKUP: begin
               state_ff <= (func_ff == FUNC_READ) ? S_CHECK : S_RMW;
            end
            S_RMW: begin
               state_ff <= S_DONE;
            end
            S_CHECK: begin
               work_ff.point_count <= ram_rdata.count;
               state_ff <= (ram_rdata.count != '0) ? S_DIV : S_DONE;
            end
            S_DIV: begin
               if (mean_done) begin
                  work_ff.mean_height_mm <= mean_val[15:0];
                  work_ff.obstacle       <= mean_val > MEAN_W'(thr_ff);
                  state_ff               <= S_DONE;
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= work_ff;
                  if (clr_pend_ff) begin
                     clr_pend_ff <= 1'b0;
                     state_ff    <= S_CLEAR;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_data_ff};

   a_bin_done_in_bin: assert property (@(posedge clock) disable iff (reset)
      bin_done |-> state_ff == S_BIN)
      else $error("index divider finished outside its wait state");

   a_mean_done_in_div: assert property (@(posedge clock) disable iff (reset)
      mean_done |-> state_ff == S_DIV)
      else $error("mean divider finished outside its wait state");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside the done state");

   a_write_in_grid: assert property (@(posedge clock) disable iff (reset)
      ram_wen |-> ram_waddr < ADDR_W'(NUM_CELLS))
      else $error("cell write beyond the grid");

endmodule

### rtl/core/hgom_cell_ram.sv
// Cell store of the grid: one write port, one read port, registered read data.
// Uses hgom_pkg for the depth and the cell layout.
module hgom_cell_ram
   import hgom_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  cell_type          wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output cell_type          rd_data
);

   cell_type cell_mem_ff [NUM_CELLS];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cell_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cell_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/hgom_bin_div.sv
// Two-lane restoring divider that turns the lateral offset and the forward
// distance into cell indexes, one quotient bit per cycle. Uses hgom_pkg.
module hgom_bin_div
   import hgom_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CS_W-1:0]  divisor,
   input  logic [EXT_W-1:0] dvd_a,
   input  logic [EXT_W-1:0] dvd_b,
   output logic             done,
   output logic [BIN_W-1:0] quot_a,
   output logic [BIN_W-1:0] quot_b
);

   localparam int STEP_W = $clog2(BIN_W);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [BDIV_W-1:0] dsr_ff;
   logic [BDIV_W-1:0] rem_a_ff;
   logic [BDIV_W-1:0] rem_b_ff;
   logic [BIN_W-1:0]  qa_ff;
   logic [BIN_W-1:0]  qb_ff;
   logic              ge_a;
   logic              ge_b;

   assign ge_a = rem_a_ff >= dsr_ff;
   assign ge_b = rem_b_ff >= dsr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(BIN_W - 1);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dsr_ff   <= BDIV_W'(divisor) << (BIN_W - 1);
         rem_a_ff <= BDIV_W'(dvd_a);
         rem_b_ff <= BDIV_W'(dvd_b);
         qa_ff    <= '0;
         qb_ff    <= '0;
      end else if (busy_ff) begin
         dsr_ff   <= dsr_ff >> 1;
         rem_a_ff <= ge_a ? rem_a_ff - dsr_ff : rem_a_ff;
         rem_b_ff <= ge_b ? rem_b_ff - dsr_ff : rem_b_ff;
         qa_ff    <= {qa_ff[BIN_W-2:0], ge_a};
         qb_ff    <= {qb_ff[BIN_W-2:0], ge_b};
      end
   end

   assign done   = done_ff;
   assign quot_a = qa_ff;
   assign quot_b = qb_ff;

endmodule

### rtl/core/hgom_mean_div.sv
// Radix-2 restoring divider for the cell mean: signed sum over point count,
// truncated toward zero, one quotient bit per cycle. Uses hgom_pkg.
module hgom_mean_div
   import hgom_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [SUM_W-1:0]  dividend,
   input  logic [CNT_W-1:0]         divisor,
   output logic                     done,
   output logic signed [MEAN_W-1:0] mean
);

   localparam int STEP_W = $clog2(SUM_W);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] step_ff;
   logic              neg_ff;
   logic [SUM_W-1:0]  dvd_ff;
   logic [CNT_W-1:0]  dsr_ff;
   logic [CNT_W-1:0]  rem_ff;
   logic [CNT_W:0]    rem_sh;
   logic              ge;
   logic [CNT_W:0]    rem_sub;
   logic [SUM_W-1:0]  mag;

   assign mag     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
   assign rem_sh  = {rem_ff, dvd_ff[SUM_W-1]};
   assign ge      = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= STEP_W'(SUM_W - 1);
         end else if (busy_ff) begin
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[SUM_W-1];
         dvd_ff <= mag;
         dsr_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         dvd_ff <= {dvd_ff[SUM_W-2:0], ge};
      end
   end

   assign done = done_ff;
   assign mean = neg_ff ? -$signed(dvd_ff[MEAN_W-1:0]) : $signed(dvd_ff[MEAN_W-1:0]);

endmodule

### tb/tb_height_grid_obstacle_mapper.sv
// Testbench for height_grid_obstacle_mapper: directed and random request streams against
// a behavioral height map predictor, with random idling on both stream sides.
// Depends on hgom_pkg and the height_grid_obstacle_mapper RTL only.
module tb_height_grid_obstacle_mapper;
   import hgom_pkg::*;

   typedef enum logic [1:0] {
      FUNC_ADD_POINT = 2'd0,
      FUNC_READ_CELL = 2'd1,
      FUNC_NEW_FRAME = 2'd2,
      FUNC_UNUSED    = 2'd3
   } map_func_type;

   typedef struct packed {
      logic                    in_range;
      logic signed [COORD_W-1:0] mean;
      logic [CNT_W-1:0]        count;
      logic                    obstacle;
   } cell_answer_type;

   localparam logic REG_CELL_SIZE   = 1'b0;
   localparam logic REG_THRESHOLD   = 1'b1;
   localparam int   SETTLE_CYCLES   = 60;
   localparam int   WATCHDOG_LIMIT  = 3 * NUM_CELLS;
   localparam int   MAX_REPORTS     = 10;
   localparam int   NUM_PHASES      = 6;
   localparam int   ITEMS_PER_PHASE = 225;
   localparam int   FILLED_KEEP     = 64;

   logic               clock;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [71:0]        req_tdata;
   logic [1:0]         req_tuser;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [39:0]        rsp_tdata;
   logic               csr_wen;
   logic               csr_index;
   logic [CSR_W-1:0]   csr_wdata;

   // height map predictor state
   int                       cell_sum [NUM_CELLS];
   logic [CNT_W-1:0]         cell_count [NUM_CELLS];
   logic [CS_W-1:0]          cfg_cell_size;
   logic signed [THR_W-1:0]  cfg_threshold;
   logic [2*IDX_W-1:0]       filled_cells [$];

   cell_answer_type answer_q [$];
   int           mismatches = 0;
   int           idle_cycles = 0;
   int           req_gap_max;
   int           rsp_stall_max;
   int           rsp_stall_left = 0;
   int           requests_sent;
   int           points_kept;
   int           filled_reads = 0;

   height_grid_obstacle_mapper i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void clear_height_map();
      for (int i = 0; i < NUM_CELLS; i++) begin
         cell_sum[i]   = 0;
         cell_count[i] = '0;
      end
      filled_cells.delete();
   endfunction

   function automatic cell_answer_type apply_to_height_map(
      map_func_type f, logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
      logic signed [COORD_W-1:0] z, logic [IDX_W-1:0] r, logic [IDX_W-1:0] col);
      cell_answer_type a;
      longint       c;
      longint       half;
      longint       extent;
      longint       col_n;
      longint       row_m;
      longint       cnt;
      longint       mean;
      int           idx;
      a      = '0;
      c      = (cfg_cell_size == 0) ? 1 : longint'(cfg_cell_size);
      half   = HALF_CELLS * c;
      extent = GRID_CELLS * c;
      case (f)
         FUNC_ADD_POINT: begin
            if (longint'(x) > -half && longint'(x) < half &&
                longint'(z) > 0 && longint'(z) < extent) begin
               col_n = (longint'(x) + half) / c;
               row_m = longint'(z) / c;
               if (col_n >= GRID_CELLS) col_n = GRID_CELLS - 1;
               if (row_m >= GRID_CELLS) row_m = GRID_CELLS - 1;
               idx = int'(row_m) * GRID_CELLS + int'(col_n);
               if (cell_count[idx] != {CNT_W{1'b1}}) begin
                  cell_sum[idx]   = cell_sum[idx] + int'(y);
                  cell_count[idx] = cell_count[idx] + 1'b1;
               end
               a.in_range = 1'b1;
               filled_cells.push_back({IDX_W'(row_m), IDX_W'(col_n)});
               if (filled_cells.size() > FILLED_KEEP) void'(filled_cells.pop_front());
            end
         end
         FUNC_READ_CELL: begin
            if (r < GRID_CELLS && col < GRID_CELLS) begin
               idx        = int'(r) * GRID_CELLS + int'(col);
               cnt        = longint'(cell_count[idx]);
               a.in_range = 1'b1;
               if (cnt != 0) begin
                  mean       = longint'(cell_sum[idx]) / cnt;
                  a.mean     = mean[COORD_W-1:0];
                  a.count    = cell_count[idx];
                  a.obstacle = (mean > longint'(cfg_threshold));
               end
            end
         end
         FUNC_NEW_FRAME: clear_height_map();
         default: ;
      endcase
      return a;
   endfunction

   function automatic logic signed [COORD_W-1:0] clamp_coord(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[COORD_W-1:0];
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord();
      return COORD_W'($urandom);
   endfunction

   function automatic logic [IDX_W-1:0] rand_idx();
      return IDX_W'($urandom);
   endfunction

   task automatic send_request(map_func_type f, logic signed [COORD_W-1:0] x,
                               logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
                               logic [IDX_W-1:0] r, logic [IDX_W-1:0] col);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= f;
      req_tdata  <= {6'b0, col, r, z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      answer_q.push_back(apply_to_height_map(f, x, y, z, r, col));
      requests_sent++;
      if (f == FUNC_ADD_POINT && answer_q[$].in_range) points_kept++;
   endtask

   task automatic add_point(int x, int y, int z);
      send_request(FUNC_ADD_POINT, COORD_W'(x), COORD_W'(y), COORD_W'(z),
                   rand_idx(), rand_idx());
   endtask

   task automatic read_cell(int r, int col);
      send_request(FUNC_READ_CELL, rand_coord(), rand_coord(), rand_coord(),
                   IDX_W'(r), IDX_W'(col));
   endtask

   task automatic wait_for_answers();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (answer_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [CSR_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      @(posedge clock);
      if (idx == REG_CELL_SIZE) cfg_cell_size = value[CS_W-1:0];
      else cfg_threshold = value;
   endtask

   task automatic random_point(output logic signed [COORD_W-1:0] x,
                               output logic signed [COORD_W-1:0] y,
                               output logic signed [COORD_W-1:0] z);
      longint c;
      longint half;
      longint extent;
      int     k;
      c      = (cfg_cell_size == 0) ? 1 : longint'(cfg_cell_size);
      half   = HALF_CELLS * c;
      extent = GRID_CELLS * c;
      k      = $urandom_range(0, 99);
      x = clamp_coord(longint'($urandom_range(0, 32'(8 * c - 1))) - 4 * c);
      z = clamp_coord(longint'($urandom_range(1, 32'(8 * c))));
      if ($urandom_range(0, 4) == 0) y = rand_coord();
      else y = clamp_coord(longint'($urandom_range(0, 4000)) - 2000);
      if (k >= 85) begin
         x = rand_coord();
         y = rand_coord();
         z = rand_coord();
      end else if (k >= 70) begin
         case ($urandom_range(0, 4))
            0: x = clamp_coord(-half);
            1: x = clamp_coord(-half + 1);
            2: x = clamp_coord(half - 1);
            3: x = clamp_coord(half);
            default: ;
         endcase
         case ($urandom_range(0, 4))
            0: z = 0;
            1: z = 1;
            2: z = clamp_coord(extent - 1);
            3: z = clamp_coord(extent);
            default: ;
         endcase
      end
   endtask

   task automatic test_grid_bounds();
      read_cell(0, 0);
      add_point(-1999, 32767, 1);
      add_point(1999, -32768, 3999);
      add_point(-2000, 5, 50);
      add_point(2000, 5, 50);
      add_point(0, 5, 0);
      add_point(0, 5, 4000);
      add_point(-32768, 5, -32768);
      add_point(32767, 5, 32767);
      read_cell(0, 0);
      read_cell(GRID_CELLS - 1, GRID_CELLS - 1);
   endtask

   task automatic test_mean_threshold();
      add_point(0, 150, 5);
      add_point(5, 51, 9);
      read_cell(0, HALF_CELLS);
      add_point(10, 101, 10);
      read_cell(1, HALF_CELLS + 1);
      add_point(-10, -7, 10);
      add_point(-1, -8, 19);
      read_cell(1, HALF_CELLS - 1);
   endtask

   task automatic test_out_of_grid_reads();
      read_cell(GRID_CELLS, 0);
      read_cell(0, GRID_CELLS);
      read_cell(511, 511);
   endtask

   task automatic test_unused_and_new_frame();
      send_request(FUNC_UNUSED, rand_coord(), rand_coord(), rand_coord(), rand_idx(), rand_idx());
      read_cell(0, 0);
      send_request(FUNC_NEW_FRAME, rand_coord(), rand_coord(), rand_coord(),
                   rand_idx(), rand_idx());
      read_cell(0, 0);
   endtask

   task automatic test_random_phases();
      logic [CS_W-1:0]         cs;
      logic signed [THR_W-1:0] thr;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [2*IDX_W-1:0]      pick;
      int                      k;
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_for_answers();
         case (p)
            0: begin cs = 1023; thr = 16'sh7fff; end
            1: begin cs = 0;    thr = 16'sh8000; end
            2: begin cs = 1;    thr = THR_W'($urandom_range(0, 400) - 200); end
            3: begin
               cs  = CS_W'($urandom_range(2, 1000));
               thr = THR_W'($urandom_range(0, 1000) - 500);
            end
            4: begin cs = 1000; thr = 0; end
            default: begin cs = CS_W'($urandom); thr = THR_W'($urandom); end
         endcase
         write_csr(REG_CELL_SIZE, {6'($urandom), cs});
         write_csr(REG_THRESHOLD, thr);
         if (p == 1 || p == 3)
            send_request(FUNC_NEW_FRAME, rand_coord(), rand_coord(), rand_coord(),
                         rand_idx(), rand_idx());
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i % 45 == 0) begin
               req_gap_max   = ($urandom_range(0, 2) == 0) ? 0 : 6;
               rsp_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 6;
            end
            if (p == 2 && i == ITEMS_PER_PHASE / 2) wait_for_answers();
            k = $urandom_range(0, 99);
            if (k < 55) begin
               random_point(x, y, z);
               send_request(FUNC_ADD_POINT, x, y, z, rand_idx(), rand_idx());
            end else if (k < 96) begin
               k = $urandom_range(0, 99);
               if (k < 70 && filled_cells.size() != 0) begin
                  pick = filled_cells[$urandom_range(0, filled_cells.size() - 1)];
                  read_cell(int'(pick[2*IDX_W-1:IDX_W]), int'(pick[IDX_W-1:0]));
               end else if (k < 85) begin
                  read_cell($urandom_range(0, GRID_CELLS - 1), $urandom_range(0, GRID_CELLS - 1));
               end else begin
                  read_cell($urandom_range(0, 511), $urandom_range(0, 511));
               end
            end else begin
               send_request(FUNC_UNUSED, rand_coord(), rand_coord(), rand_coord(),
                            rand_idx(), rand_idx());
            end
         end
      end
   endtask

   // result side: random stall per result, check each accepted result
   always @(posedge clock) begin
      cell_answer_type want;
      cell_answer_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.in_range = rsp_tdata[0];
         got.mean     = rsp_tdata[16:1];
         got.count    = rsp_tdata[32:17];
         got.obstacle = rsp_tdata[33];
         if (answer_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("ERROR: result %h arrived with no request pending", rsp_tdata);
         end else begin
            want = answer_q.pop_front();
            if (got.count != 0) filled_reads++;
            if (got.in_range !== want.in_range || got.mean !== want.mean ||
                got.count !== want.count || got.obstacle !== want.obstacle) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("ERROR: expected in_range=%0b mean=%0d count=%0d obstacle=%0b, %s",
                           want.in_range, want.mean, want.count, want.obstacle,
                           $sformatf("got in_range=%0b mean=%0d count=%0d obstacle=%0b",
                                     got.in_range, got.mean, got.count, got.obstacle));
            end
         end
         rsp_stall_left = $urandom_range(0, rsp_stall_max);
      end
      if (rsp_stall_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("ERROR: no request or result moved for %0d cycles", idle_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      csr_wen        = 1'b0;
      csr_index      = 1'b0;
      csr_wdata      = '0;
      req_gap_max    = 6;
      rsp_stall_max  = 6;
      requests_sent  = 0;
      points_kept    = 0;
      cfg_cell_size  = 10;
      cfg_threshold  = 100;
      clear_height_map();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_grid_bounds();
      test_mean_threshold();
      test_out_of_grid_reads();
      test_unused_and_new_frame();
      test_random_phases();
      wait_for_answers();

      if (answer_q.size() != 0) mismatches++;
      $display("Sent %0d requests over %0d cell size and threshold settings plus reset values;",
               requests_sent, NUM_PHASES);
      $display("%0d points landed in the grid, %0d reads returned occupied cells, %0d mismatches",
               points_kept, filled_reads, mismatches);
      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
